@@ hw/rtl/ogcc_pkg.sv @@
`timescale 1ns / 1ps

package ogcc_pkg;

    // cell classes
    localparam logic [1:0] CLASS_NORMAL    = 2'd0;
    localparam logic [1:0] CLASS_CANCER    = 2'd1;
    localparam logic [1:0] CLASS_QUIESCENT = 2'd2;
    localparam logic [1:0] CLASS_MACRO     = 2'd3;

    // item kinds
    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // register indexes
    localparam logic [1:0] REG_ENTER    = 2'd0;
    localparam logic [1:0] REG_LEAVE    = 2'd1;
    localparam logic [1:0] REG_CRITICAL = 2'd2;
    localparam logic [1:0] REG_STEP     = 2'd3;

    localparam logic [15:0] ENTER_RESET    = 16'd2278;
    localparam logic [15:0] LEAVE_RESET    = 16'd2509;
    localparam logic [15:0] CRITICAL_RESET = 16'd4000;
    localparam logic [15:0] STEP_RESET     = 16'd128;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // class constants: 256*C0*10 offset and Tmin
    localparam logic [19:0] C_CANCER    = 20'd3584;
    localparam logic [19:0] C_NORMAL    = 20'd7680;
    localparam logic [11:0] TMIN_CANCER = 12'd1600;
    localparam logic [11:0] TMIN_NORMAL = 12'd3000;

    // divider geometry: quotient is known to stay below 2^QUOT_W
    localparam int NUM_W  = 58;
    localparam int DEN_W  = 31;
    localparam int QUOT_W = 28;
    localparam int CNT_W  = $clog2(QUOT_W + 1);

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

@@ hw/rtl/oxygen_gated_cell_cycle_step.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake                 content
// s_axis    in   s_axis_tvalid/tready      load or time-step item
// m_axis    out  m_axis_tvalid/tready      cell status after the item
// apb       in   psel/penable/pready       four 16-bit registers at 0x0..0xc
//
// a time step that leaves the cell in G1 runs through these steps from accept to result:
// decide, two multiply stages, divider load, 28 divide steps, quotient capture, commit
// other steps and loads go straight from decide to commit; the next item is taken once the
// sequencer is back in idle, the result register may still hold an item
// a stalled m_axis only holds the commit stage; reset clears cell state and
// restores register defaults

module oxygen_gated_cell_cycle_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // oxygen_level[15:0], time_now[55:16], class_in[57:56], start_progress[88:58]
    input  logic [95:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // divide_now[0], class_out[2:1], in_g_zero[3], labelled[4],
    // progress_out[36:5], quiescent_out[52:37]
    output logic [55:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ogcc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    // configuration
    logic [15:0] enter_reg, leave_reg, critical_reg, step_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_reg    <= ENTER_RESET;
            leave_reg    <= LEAVE_RESET;
            critical_reg <= CRITICAL_RESET;
            step_reg     <= STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ENTER:    enter_reg    <= pwdata[15:0];
                REG_LEAVE:    leave_reg    <= pwdata[15:0];
                REG_CRITICAL: critical_reg <= pwdata[15:0];
                REG_STEP:     step_reg     <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ENTER:    prdata = {16'b0, enter_reg};
            REG_LEAVE:    prdata = {16'b0, leave_reg};
            REG_CRITICAL: prdata = {16'b0, critical_reg};
            REG_STEP:     prdata = {16'b0, step_reg};
            default:      prdata = '0;
        endcase
    end

    // sequencer and cell state
    state_t      state_reg;
    logic        kind_reg;
    logic [15:0] oxy_reg;
    logic [39:0] now_reg;
    logic [1:0]  cls_in_reg;
    logic [30:0] start_reg;

    logic [1:0]  class_reg;
    logic        phase_reg;
    logic [31:0] progress_reg;
    logic [39:0] onset_reg;
    logic [15:0] quies_reg;
    logic        label_reg;

    logic [31:0]       prod_reg;
    logic [19:0]       d1_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              start_div_reg;
    logic [QUOT_W-1:0] gain_reg;

    logic        m_valid_reg;
    logic [55:0] m_data_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign div_req.start = start_div_reg;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    ogcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // oxygen gating on the latched item
    logic [1:0]  cls_next;
    logic        phase_next;
    logic [39:0] onset_next;
    logic [15:0] quies_next;
    logic        label_next;
    logic [39:0] diff;
    logic [31:0] mins;

    always_comb
    begin
        cls_next   = class_reg;
        phase_next = phase_reg;
        onset_next = onset_reg;
        quies_next = quies_reg;
        label_next = label_reg;
        diff       = '0;
        mins       = '0;
        if (kind_reg == KIND_LOAD)
        begin
            cls_next   = cls_in_reg;
            phase_next = (cls_in_reg == CLASS_QUIESCENT) || (cls_in_reg == CLASS_MACRO);
            onset_next = (cls_in_reg == CLASS_QUIESCENT) ? now_reg : '0;
            quies_next = '0;
            label_next = 1'b0;
        end
        else
        begin
            if (class_reg == CLASS_CANCER && oxy_reg < enter_reg)
            begin
                cls_next   = CLASS_QUIESCENT;
                onset_next = now_reg;
                phase_next = 1'b1;
            end
            if (cls_next == CLASS_QUIESCENT)
            begin
                if (oxy_reg < leave_reg)
                begin
                    diff       = (now_reg >= onset_next) ? (now_reg - onset_next) : '0;
                    mins       = diff[39:8];
                    quies_next = (|mins[31:16]) ? 16'hffff : mins[15:0];
                    if (quies_next >= critical_reg)
                    begin
                        label_next = 1'b1;
                    end
                end
                else
                begin
                    quies_next = '0;
                    onset_next = '0;
                    phase_next = 1'b0;
                    cls_next   = CLASS_CANCER;
                end
            end
            if (cls_next == CLASS_MACRO)
            begin
                phase_next = 1'b1;
            end
        end
    end

    // multiply stages and commit arithmetic
    logic        cancer;
    logic [19:0] oxy_x10;
    logic [34:0] prod_x5;
    logic [11:0] tmin;
    logic [31:0] den_full;
    logic [32:0] sum;
    logic [31:0] prog_new;
    logic        divide_new;

    assign cancer   = (class_reg == CLASS_CANCER);
    assign oxy_x10  = {1'b0, oxy_reg, 3'b0} + {3'b0, oxy_reg, 1'b0};
    assign prod_x5  = {3'b0, prod_reg} + {1'b0, prod_reg, 2'b0};
    assign tmin     = cancer ? TMIN_CANCER : TMIN_NORMAL;
    assign den_full = {12'b0, d1_reg} * {20'b0, tmin};

    always_comb
    begin
        sum        = {1'b0, progress_reg} + {{(33 - QUOT_W){1'b0}}, gain_reg};
        prog_new   = sum[32] ? 32'hffff_ffff : sum[31:0];
        divide_new = 1'b0;
        if (kind_reg == KIND_LOAD)
        begin
            prog_new = {1'b0, start_reg};
        end
        else if (prog_new > ONE_Q30)
        begin
            prog_new   = '0;
            divide_new = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            class_reg     <= CLASS_NORMAL;
            phase_reg     <= 1'b0;
            progress_reg  <= '0;
            onset_reg     <= '0;
            quies_reg     <= '0;
            label_reg     <= 1'b0;
            start_div_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            start_div_reg <= 1'b0;
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    class_reg <= cls_next;
                    phase_reg <= phase_next;
                    onset_reg <= onset_next;
                    quies_reg <= quies_next;
                    label_reg <= label_next;
                    if (kind_reg == KIND_STEP && !phase_next)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    start_div_reg <= 1'b1;
                    state_reg     <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        progress_reg <= prog_new;
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= {3'b0, quies_reg, prog_new, label_reg,
                                         phase_reg, class_reg, divide_new};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            kind_reg   <= s_axis_tuser;
            oxy_reg    <= s_axis_tdata[15:0];
            now_reg    <= s_axis_tdata[55:16];
            cls_in_reg <= s_axis_tdata[57:56];
            start_reg  <= s_axis_tdata[88:58];
        end
        if (state_reg == ST_DECIDE)
        begin
            gain_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= {16'b0, step_reg} * {16'b0, oxy_reg};
            d1_reg   <= (cancer ? C_CANCER : C_NORMAL) + oxy_x10;
        end
        if (state_reg == ST_SCALE)
        begin
            num_reg <= {prod_x5, {(NUM_W - 35){1'b0}}};
            den_reg <= den_full[DEN_W-1:0];
        end
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            gain_reg <= div_rsp.quot;
        end
    end

    // checks
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while the previous one is in flight");

    a_macro_rests: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:1] != CLASS_MACRO || m_axis_tdata[3])
        else $error("macrophage reported outside G0");

    a_div_start_gated: assert property (@(posedge clk) disable iff (!rst_n)
        start_div_reg |-> kind_reg == KIND_STEP && !phase_reg)
        else $error("divider started for a resting cell or a load");

endmodule

@@ hw/rtl/ogcc_div.sv @@
`timescale 1ns / 1ps

module ogcc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ogcc_pkg::div_req_t  req,
    output ogcc_pkg::div_rsp_t  rsp
);
    import ogcc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [31:0] shifted;
    logic [32:0] trial;

    // one restoring step per cycle through the shared subtractor
    assign shifted = {rem_reg[30:0], low_reg[QUOT_W-1]};
    assign trial   = {1'b0, shifted} - {2'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(QUOT_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // upper part is already below the divisor
            rem_reg  <= {{(32 - (NUM_W - QUOT_W)){1'b0}}, req.num[NUM_W-1:QUOT_W]};
            low_reg  <= req.num[QUOT_W-1:0];
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], ~trial[32]};
            rem_reg  <= trial[32] ? shifted : trial[31:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ bench/oxygen_gated_cell_cycle_step_tb.sv @@
`timescale 1ns / 1ps

module oxygen_gated_cell_cycle_step_tb;

    import ogcc_pkg::*;

    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    // status word as it sits in m_axis_tdata[52:0]
    typedef struct packed {
        logic [15:0] quiescent;
        logic [31:0] progress;
        logic        labelled;
        logic        in_g_zero;
        logic [1:0]  cell_class;
        logic        divide_now;
    } cell_status_t;

    localparam cell_status_t NO_STATUS = '0;

    typedef struct {
        logic         is_reg;
        logic [1:0]   reg_idx;
        logic [15:0]  reg_val;
        logic         kind;
        logic [15:0]  oxy;
        logic [39:0]  now;
        logic [1:0]   cls;
        logic [30:0]  start;
        logic         typed;
        cell_status_t want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // oxygen_level[15:0], time_now[55:16], class_in[57:56], start_progress[88:58]
    logic [95:0] s_axis_tdata;
    // kind
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // divide_now[0], class_out[2:1], in_g_zero[3], labelled[4],
    // progress_out[36:5], quiescent_out[52:37]
    logic [55:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the registers and the cell
    logic [15:0] reg_enter;
    logic [15:0] reg_leave;
    logic [15:0] reg_critical;
    logic [15:0] reg_step;
    logic [1:0]  st_class;
    logic        st_resting;
    logic [31:0] st_progress;
    logic [39:0] st_onset;
    logic [15:0] st_quiet;
    logic        st_label;

    cell_status_t due_status[$];
    cell_status_t got;
    cell_status_t want_st;
    plan_row_t    plan[$];

    logic hold_req;
    logic idle_on;
    int   fail_count;
    int   n_items;
    int   n_loads;
    int   n_checked;
    int   n_divides;
    int   n_quiet;
    int   n_labelled;

    logic [15:0] ph_enter    [6] = '{16'd2278, 16'hFFFF, 16'd0,     16'd30000, 16'd0, 16'd2278};
    logic [15:0] ph_leave    [6] = '{16'd2509, 16'd0,    16'hFFFF,  16'd20000, 16'd0, 16'd2509};
    logic [15:0] ph_critical [6] = '{16'd4000, 16'd0,    16'hFFFF,  16'd1,     16'd0, 16'd4000};
    logic [15:0] ph_step     [6] = '{16'd128,  16'd1,    16'hFFFF,  16'd2560,  16'd1, 16'd128};

    oxygen_gated_cell_cycle_step u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic cell_status_t status_of(input logic div, input logic [1:0] cls,
                                               input logic g0, input logic lab,
                                               input logic [31:0] prog, input logic [15:0] q);
        return cell_status_t'({q, prog, lab, g0, cls, div});
    endfunction

    function automatic plan_row_t item_row(input logic k, input logic [15:0] oxy,
                                           input logic [39:0] now, input logic [1:0] cls,
                                           input logic [30:0] start, input logic typed,
                                           input cell_status_t want);
        plan_row_t r;
        r.is_reg = 1'b0;
        r.reg_idx = REG_ENTER;
        r.reg_val = 16'd0;
        r.kind = k;
        r.oxy = oxy;
        r.now = now;
        r.cls = cls;
        r.start = start;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
        plan_row_t r;
        r = item_row(KIND_STEP, 16'd0, 40'd0, CLASS_NORMAL, 31'd0, 1'b0, NO_STATUS);
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // next cell status for one accepted item
    function automatic cell_status_t advance_cell(input logic k, input logic [15:0] oxy,
                                                  input logic [39:0] now,
                                                  input logic [1:0] cls,
                                                  input logic [30:0] start);
        logic [39:0] span;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] sum;
        logic        divide;
        divide = 1'b0;
        if (k == KIND_LOAD) begin
            st_class = cls;
            st_progress = {1'b0, start};
            st_resting = (cls == CLASS_QUIESCENT || cls == CLASS_MACRO);
            st_onset = (cls == CLASS_QUIESCENT) ? now : 40'd0;
            st_quiet = 16'd0;
            st_label = 1'b0;
        end
        else begin
            if (st_class == CLASS_CANCER && oxy < reg_enter) begin
                st_class = CLASS_QUIESCENT;
                st_onset = now;
                st_resting = 1'b1;
            end
            // a freshly quiescent cell is checked against the leave level straight away
            if (st_class == CLASS_QUIESCENT) begin
                if (oxy < reg_leave) begin
                    span = (now >= st_onset) ? now - st_onset : 40'd0;
                    st_quiet = (span[39:24] != 16'd0) ? 16'hFFFF : span[23:8];
                    if (st_quiet >= reg_critical)
                        st_label = 1'b1;
                end
                else begin
                    st_quiet = 16'd0;
                    st_onset = 40'd0;
                    st_resting = 1'b0;
                    st_class = CLASS_CANCER;
                end
            end
            if (st_class == CLASS_MACRO)
                st_resting = 1'b1;
            if (!st_resting) begin
                // 2560 * 2^14 scales the Q8.8 product to Q2.30
                num = 64'(reg_step) * 64'(oxy) * 64'd41943040;
                if (st_class == CLASS_CANCER)
                    den = 64'(TMIN_CANCER) * (64'(C_CANCER) + 64'd10 * 64'(oxy));
                else
                    den = 64'(TMIN_NORMAL) * (64'(C_NORMAL) + 64'd10 * 64'(oxy));
                sum = 64'(st_progress) + num / den;
                st_progress = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
            // division is checked in any class or phase
            if (st_progress > ONE_Q30) begin
                st_progress = 32'd0;
                divide = 1'b1;
            end
        end
        return status_of(divide, st_class, st_resting, st_label, st_progress, st_quiet);
    endfunction

    task automatic send_item(input logic k, input logic [15:0] oxy, input logic [39:0] now,
                             input logic [1:0] cls, input logic [30:0] start,
                             input logic typed, input cell_status_t want);
        cell_status_t predicted;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tdata = {7'd0, start, cls, now, oxy};
        s_axis_tuser = k;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predicted = advance_cell(k, oxy, now, cls, start);
        due_status.push_back(typed ? want : predicted);
        n_items++;
        if (k == KIND_LOAD)
            n_loads++;
    endtask

    // registers only change with the block idle; each write is read back
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (due_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[15:0] !== val) begin
            $error("register %0d readback: expected %0d, got %0d", idx, val, prdata[15:0]);
            fail_count++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            REG_ENTER:    reg_enter = val;
            REG_LEAVE:    reg_leave = val;
            REG_CRITICAL: reg_critical = val;
            REG_STEP:     reg_step = val;
            default:      reg_step = val;
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold when asked
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[52:0];
            n_checked++;
            if (got.divide_now)
                n_divides++;
            if (got.cell_class == CLASS_QUIESCENT)
                n_quiet++;
            if (got.labelled)
                n_labelled++;
            if (due_status.size() == 0) begin
                $error("status item with no item waiting for it");
                fail_count++;
            end
            else begin
                want_st = due_status.pop_front();
                if (got.divide_now !== want_st.divide_now) begin
                    $error("divide_now: expected %0d, got %0d",
                           want_st.divide_now, got.divide_now);
                    fail_count++;
                end
                if (got.cell_class !== want_st.cell_class) begin
                    $error("class_out: expected %0d, got %0d",
                           want_st.cell_class, got.cell_class);
                    fail_count++;
                end
                if (got.in_g_zero !== want_st.in_g_zero) begin
                    $error("in_g_zero: expected %0d, got %0d",
                           want_st.in_g_zero, got.in_g_zero);
                    fail_count++;
                end
                if (got.labelled !== want_st.labelled) begin
                    $error("labelled: expected %0d, got %0d",
                           want_st.labelled, got.labelled);
                    fail_count++;
                end
                if (got.progress !== want_st.progress) begin
                    $error("progress_out: expected %0h, got %0h",
                           want_st.progress, got.progress);
                    fail_count++;
                end
                if (got.quiescent !== want_st.quiescent) begin
                    $error("quiescent_out: expected %0d, got %0d",
                           want_st.quiescent, got.quiescent);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int          p;
        int          n;
        int          pick;
        logic        k;
        logic [15:0] oxy;
        logic [1:0]  cls;
        logic [30:0] start;
        logic [39:0] clock_now;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_STEP;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        idle_on = 1'b1;
        fail_count = 0;
        n_items = 0;
        n_loads = 0;
        n_checked = 0;
        n_divides = 0;
        n_quiet = 0;
        n_labelled = 0;

        reg_enter = ENTER_RESET;
        reg_leave = LEAVE_RESET;
        reg_critical = CRITICAL_RESET;
        reg_step = STEP_RESET;
        st_class = CLASS_NORMAL;
        st_resting = 1'b0;
        st_progress = 32'd0;
        st_onset = 40'd0;
        st_quiet = 16'd0;
        st_label = 1'b0;

        // directed part, reset register values first
        plan.push_back(item_row(KIND_STEP, 16'd0, 40'd0, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_NORMAL, 1'b0, 1'b0, 32'd0, 16'd0)));
        plan.push_back(item_row(KIND_LOAD, 16'd0, 40'd0, CLASS_CANCER, 31'(ONE_Q30), 1'b1,
                                status_of(1'b0, CLASS_CANCER, 1'b0, 1'b0, ONE_Q30, 16'd0)));
        plan.push_back(item_row(KIND_STEP, 16'hFFFF, 40'd0, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b1, CLASS_CANCER, 1'b0, 1'b0, 32'd0, 16'd0)));
        // low oxygen: cancer turns quiescent
        plan.push_back(item_row(KIND_STEP, 16'd0, 40'd1000, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_QUIESCENT, 1'b1, 1'b0, 32'd0, 16'd0)));
        plan.push_back(item_row(KIND_STEP, 16'd0, 40'd26600, CLASS_NORMAL, 31'd0, 1'b0,
                                NO_STATUS));
        // time behind the onset counts as zero
        plan.push_back(item_row(KIND_STEP, 16'd2508, 40'd500, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_QUIESCENT, 1'b1, 1'b0, 32'd0, 16'd0)));
        plan.push_back(item_row(KIND_STEP, 16'd0, 40'hFF_FFFF_FFFF, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_QUIESCENT, 1'b1, 1'b1, 32'd0, 16'hFFFF)));
        plan.push_back(item_row(KIND_STEP, 16'd2509, 40'd2000, CLASS_NORMAL, 31'd0, 1'b0,
                                NO_STATUS));
        plan.push_back(item_row(KIND_LOAD, 16'hFFFF, 40'hFF_FFFF_FFFF, CLASS_MACRO,
                                31'h7FFF_FFFF, 1'b1,
                                status_of(1'b0, CLASS_MACRO, 1'b1, 1'b0, 32'h7FFF_FFFF, 16'd0)));
        // over one while resting still divides
        plan.push_back(item_row(KIND_STEP, 16'd5000, 40'd0, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b1, CLASS_MACRO, 1'b1, 1'b0, 32'd0, 16'd0)));
        plan.push_back(item_row(KIND_LOAD, 16'd0, 40'd0, CLASS_NORMAL, 31'h3FFF_0000, 1'b1,
                                status_of(1'b0, CLASS_NORMAL, 1'b0, 1'b0, 32'h3FFF_0000, 16'd0)));
        plan.push_back(item_row(KIND_STEP, 16'hFFFF, 40'd100, CLASS_NORMAL, 31'd0, 1'b0,
                                NO_STATUS));
        plan.push_back(item_row(KIND_LOAD, 16'd0, 40'd5000, CLASS_QUIESCENT, 31'd12345, 1'b1,
                                status_of(1'b0, CLASS_QUIESCENT, 1'b1, 1'b0, 32'd12345, 16'd0)));
        plan.push_back(item_row(KIND_STEP, 16'd0, 40'd1029000, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_QUIESCENT, 1'b1, 1'b1, 32'd12345,
                                          16'd4000)));
        // zero step size: no gain at all
        plan.push_back(reg_row(REG_STEP, 16'd0));
        plan.push_back(item_row(KIND_LOAD, 16'd0, 40'd0, CLASS_CANCER, 31'd100, 1'b1,
                                status_of(1'b0, CLASS_CANCER, 1'b0, 1'b0, 32'd100, 16'd0)));
        plan.push_back(item_row(KIND_STEP, 16'hFFFF, 40'd10, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_CANCER, 1'b0, 1'b0, 32'd100, 16'd0)));
        // enter above leave: fresh quiescence reverts within the same step
        plan.push_back(reg_row(REG_ENTER, 16'hFFFF));
        plan.push_back(reg_row(REG_LEAVE, 16'd0));
        plan.push_back(reg_row(REG_STEP, 16'hFFFF));
        plan.push_back(item_row(KIND_STEP, 16'd1000, 40'd7000, CLASS_NORMAL, 31'd0, 1'b0,
                                NO_STATUS));
        plan.push_back(reg_row(REG_CRITICAL, 16'd0));
        plan.push_back(item_row(KIND_LOAD, 16'd0, 40'd300, CLASS_QUIESCENT, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_QUIESCENT, 1'b1, 1'b0, 32'd0, 16'd0)));
        plan.push_back(item_row(KIND_STEP, 16'd0, 40'd300, CLASS_NORMAL, 31'd0, 1'b1,
                                status_of(1'b0, CLASS_CANCER, 1'b0, 1'b0, 32'd0, 16'd0)));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_item(plan[i].kind, plan[i].oxy, plan[i].now, plan[i].cls, plan[i].start,
                          plan[i].typed, plan[i].want);
        end

        // random part: mostly step runs between loads, time mostly moving forward
        clock_now = 40'd0;
        for (p = 0; p < 6; p++) begin
            if (p == 5)
                idle_on = 1'b0;
            write_reg(REG_ENTER, (p == 4) ? 16'($urandom) : ph_enter[p]);
            write_reg(REG_LEAVE, (p == 4) ? 16'($urandom) : ph_leave[p]);
            write_reg(REG_CRITICAL, (p == 4) ? 16'($urandom_range(0, 8000)) : ph_critical[p]);
            write_reg(REG_STEP, (p == 4) ? 16'($urandom_range(1, 65535)) : ph_step[p]);
            if (p == 4)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                oxy = 16'($urandom);
                cls = 2'($urandom);
                start = 31'($urandom);
                pick = $urandom_range(0, 29);
                if (pick == 0)
                    clock_now = 40'({$urandom, $urandom});
                else if (pick == 1)
                    clock_now = clock_now - 40'($urandom_range(0, 2048));
                else if (pick == 2)
                    clock_now = clock_now + 40'($urandom_range(0, 1 << 28));
                else
                    clock_now = clock_now + 40'($urandom_range(0, 1 << 16));
                if ($urandom_range(0, 7) == 0) begin
                    k = KIND_LOAD;
                    if ($urandom_range(0, 2) != 0)
                        cls = CLASS_CANCER;
                    case ($urandom_range(0, 5))
                        0, 1:    start = 31'(ONE_Q30) - 31'($urandom_range(0, 1 << 22));
                        2:       start = 31'($urandom_range(0, 32'h4000_0000));
                        3:       start = 31'($urandom);
                        4:       start = 31'd0;
                        default: start = 31'(ONE_Q30);
                    endcase
                end
                else begin
                    k = KIND_STEP;
                    case ($urandom_range(0, 5))
                        0:       oxy = reg_enter + 16'($urandom_range(0, 6)) - 16'd3;
                        1:       oxy = reg_leave + 16'($urandom_range(0, 6)) - 16'd3;
                        2:       oxy = 16'($urandom);
                        3:       oxy = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
                        default: oxy = 16'($urandom_range(8000, 65535));
                    endcase
                end
                send_item(k, oxy, clock_now, cls, start, 1'b0, NO_STATUS);
            end
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (due_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d items (%0d loads) over the reset, extreme and random settings",
                 n_items, n_loads);
        $display("summary: %0d statuses checked, %0d divisions, %0d quiescent, %0d labelled",
                 n_checked, n_divides, n_quiet, n_labelled);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
